/* src/scalar_kalman_filter_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the scalar Kalman filter
// Shared property forms used by the checker module.
// ---------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_ASSERT_SVH

// The condition implies the consequence in the same cycle.
`define SKF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scalar_kalman_filter assertion failed");

// The condition implies the consequence in the next cycle.
`define SKF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scalar_kalman_filter assertion failed");

`endif

/* src/skf_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Scalar Kalman filter package
// Types and constants shared by the filter's sequencer and arithmetic units.
// ---------------------------------------------------------------------------
package skf_pkg;

  localparam int unsigned GAIN_BITS = 16;
  localparam logic [16:0] GAIN_ONE  = 17'h10000;
  localparam logic [4:0]  DIV_STEPS = 5'd17;

  typedef enum logic [0:0] {
    REG_PROCESS_NOISE = 1'b0,
    REG_MEASURE_NOISE = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIOR,
    S_DIVL,
    S_DIVW,
    S_MULE,
    S_MULC,
    S_COVW,
    S_HOLD
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic ld_prior;
    logic div_start;
    logic ld_gain;
    logic mul_en;
    logic mul_cov;
    logic ld_est;
    logic ld_cov;
    logic ld_out;
  } ctl_t;

  typedef struct packed {
    logic               en;
    logic signed [17:0] a;
    logic signed [33:0] b;
  } mul_req_t;

endpackage

/* src/scalar_kalman_filter.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Scalar Kalman filter
// One predict and update step per measurement sample, in fixed point.
// ---------------------------------------------------------------------------
// Usage: a sample word enters on the in channel (in_valid_i, in_ready_o,
// sample_i) and one result word leaves on the out channel (out_valid_o,
// out_ready_i, estimate_o, gain_o) for every sample. The noise registers are
// written through cfg_we_i, cfg_idx_i and cfg_data_i; the user must write
// them only while the block is idle, which the block itself does not enforce.
// After a sample is taken, out_valid_o rises and in_ready_o returns in the
// same cycle, once the result is loaded. The serial gain divider runs first;
// one shared multiplier then forms the estimate and the covariance in turn.
// A result that the receiver does not take stays in the output register
// while the next sample is already processed; that sample's result then
// waits inside until the output register frees up.
// Reset clears the estimate and the covariance and loads the noise
// registers with 0.02 and 7.0 at FRAC_BITS fraction bits.
// ---------------------------------------------------------------------------
module scalar_kalman_filter #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [31:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] estimate_o,
  output logic [16:0] gain_o
);
  import skf_pkg::*;

  localparam logic [31:0] PN_RST = 32'(((64'd2 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [31:0] MN_RST = 32'(64'd7 << FRAC_BITS);
  localparam logic signed [36:0] EST_MAX = 37'sh0_7FFF_FFFF;
  localparam logic signed [36:0] EST_MIN = -37'sh0_8000_0000;

  state_e state_q, state_d;
  ctl_t   ctl;

  logic [31:0] pnoise_q, mnoise_q;
  logic signed [31:0] est_q;
  logic [31:0] cov_q;
  logic signed [31:0] sample_q;
  logic [31:0] prior_q;
  logic [32:0] denom_q;
  logic signed [32:0] diff_q;
  logic [16:0] gain_q;
  logic        out_valid_q;
  logic signed [31:0] out_est_q;
  logic [16:0] out_gain_q;

  logic [32:0] prior_sum;
  logic [31:0] prior_sat;
  logic        div_done;
  logic [16:0] div_quot;
  mul_req_t    mul_req;
  logic signed [51:0] prod;
  logic signed [51:0] prod_rnd;
  logic signed [36:0] est_sum;
  logic signed [31:0] est_new;
  logic        out_free;
  logic [16:0] gain_rest;

  assign prior_sum = {1'b0, cov_q} + {1'b0, pnoise_q};
  assign prior_sat = prior_sum[32] ? 32'hFFFF_FFFF : prior_sum[31:0];
  assign out_free  = ~out_valid_q | out_ready_i;
  assign gain_rest = GAIN_ONE - gain_q;

  skf_div u_skf_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.div_start),
    .prior_i (prior_q),
    .denom_i (denom_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    mul_req.en = ctl.mul_en;
    if (ctl.mul_cov) begin
      mul_req.a = $signed({1'b0, gain_rest});
      mul_req.b = $signed({2'b0, prior_q});
    end else begin
      mul_req.a = $signed({1'b0, gain_q});
      mul_req.b = {diff_q[32], diff_q};
    end
  end

  skf_mul u_skf_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  assign prod_rnd = prod + 52'sd32768;
  assign est_sum  = {{5{est_q[31]}}, est_q} + {prod_rnd[51], prod_rnd[51:16]};

  always_comb begin
    if (est_sum > EST_MAX) begin
      est_new = 32'sh7FFF_FFFF;
    end else if (est_sum < EST_MIN) begin
      est_new = -32'sh8000_0000;
    end else begin
      est_new = est_sum[31:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PRIOR;
        end
      end
      S_PRIOR: state_d = S_DIVL;
      S_DIVL:  state_d = S_DIVW;
      S_DIVW: begin
        if (div_done) begin
          state_d = S_MULE;
        end
      end
      S_MULE: state_d = S_MULC;
      S_MULC: state_d = S_COVW;
      S_COVW: state_d = out_free ? S_IDLE : S_HOLD;
      S_HOLD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_q)
      S_IDLE:  ctl.in_ready = 1'b1;
      S_PRIOR: ctl.ld_prior = 1'b1;
      S_DIVL:  ctl.div_start = 1'b1;
      S_DIVW:  ctl.ld_gain = div_done;
      S_MULE:  ctl.mul_en = 1'b1;
      S_MULC: begin
        ctl.ld_est  = 1'b1;
        ctl.mul_en  = 1'b1;
        ctl.mul_cov = 1'b1;
      end
      S_COVW: begin
        ctl.ld_cov = 1'b1;
        ctl.ld_out = out_free;
      end
      S_HOLD:  ctl.ld_out = out_free;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pnoise_q    <= PN_RST;
      mnoise_q    <= MN_RST;
      est_q       <= 32'sd0;
      cov_q       <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_PROCESS_NOISE: pnoise_q <= cfg_data_i;
          REG_MEASURE_NOISE: mnoise_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ctl.ld_est) begin
        est_q <= est_new;
      end
      if (ctl.ld_cov) begin
        cov_q <= prod_rnd[47:16];
      end
      if (ctl.ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.in_ready && in_valid_i) begin
      sample_q <= sample_i;
    end
    if (ctl.ld_prior) begin
      prior_q <= prior_sat;
      denom_q <= {1'b0, prior_sat} + {1'b0, mnoise_q};
      diff_q  <= {sample_q[31], sample_q} - {est_q[31], est_q};
    end
    if (ctl.ld_gain) begin
      gain_q <= div_quot;
    end
    if (ctl.ld_out) begin
      out_est_q  <= est_q;
      out_gain_q <= gain_q;
    end
  end

  assign in_ready_o  = ctl.in_ready;
  assign out_valid_o = out_valid_q;
  assign estimate_o  = out_est_q;
  assign gain_o      = out_gain_q;

endmodule

/* src/skf_div.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Serial gain divider
// Restoring divider that forms the rounded gain prior / denom in Q1.16,
// one quotient bit per cycle.
// ---------------------------------------------------------------------------
module skf_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] prior_i,
  input  logic [32:0] denom_i,
  output logic        done_o,
  output logic [16:0] quot_o
);
  import skf_pkg::*;

  logic [4:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic        zero_q, zero_d;
  logic [32:0] rem_q, rem_d;
  logic [16:0] num_q, num_d;
  logic [16:0] quo_q, quo_d;
  logic [32:0] den_q, den_d;
  logic [48:0] numer;
  logic [33:0] trial;
  logic [34:0] sub;
  logic        qbit;

  assign numer = {1'b0, prior_i, 16'b0} + {17'b0, denom_i[32:1]};
  assign trial = {rem_q, num_q[16]};
  assign sub   = {1'b0, trial} - {2'b0, den_q};
  assign qbit  = ~sub[34];

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    zero_d = zero_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      cnt_d  = DIV_STEPS;
      zero_d = (denom_i == 33'd0);
      rem_d  = {1'b0, numer[48:17]};
      num_d  = numer[16:0];
      quo_d  = 17'd0;
      den_d  = denom_i;
    end else if (cnt_q != 5'd0) begin
      cnt_d  = cnt_q - 5'd1;
      done_d = (cnt_q == 5'd1);
      rem_d  = qbit ? sub[32:0] : trial[32:0];
      num_d  = {num_q[15:0], 1'b0};
      quo_d  = {quo_q[15:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 5'd0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = zero_q ? 17'd0 : quo_q;

endmodule

/* src/skf_mul.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Shared multiplier
// Signed 18 by 34 bit multiplier with a registered product, used for both
// the estimate update and the covariance update.
// ---------------------------------------------------------------------------
module skf_mul (
  input  logic               clk_i,
  input  skf_pkg::mul_req_t  req_i,
  output logic signed [51:0] prod_o
);
  import skf_pkg::*;

  logic signed [51:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= req_i.a * req_i.b;
    end
  end

  assign prod_o = prod_q;

endmodule

/* src/skf_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Scalar Kalman filter port checker
// Concurrent checks on the filter's ports, attached by a bind statement.
// ---------------------------------------------------------------------------
`include "scalar_kalman_filter_assert.svh"

module skf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic signed [31:0] estimate_o,
  input logic [16:0] gain_o
);
  import skf_pkg::*;

  logic [48:0] out_word;

  assign out_word = {estimate_o, gain_o};

  `SKF_ASSERT_SAME(a_gain_range, out_valid_o, gain_o <= GAIN_ONE)
  `SKF_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `SKF_ASSERT_SAME(a_result_frees_input, $rose(out_valid_o), in_ready_o)
  `SKF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word))

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (.*);

/* sim/scalar_kalman_filter_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Scalar Kalman filter testbench
// Drives measurement samples through the filter and checks every estimate
// and gain against an in-bench fixed-point predictor or, for typed rows,
// against the values in the directed table, which covers reset, field
// extremes, zero noise, saturated covariance and full and zero gain; random
// samples under many noise settings and three flow-control mixes follow.
// ---------------------------------------------------------------------------
module scalar_kalman_filter_tb;
  import skf_pkg::*;

  localparam int unsigned FRAC_BITS = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int N_DIRECTED = 25;
  localparam int SEGMENTS = 5;
  localparam int SEG_SAMPLES = 70;
  localparam logic [31:0] DEF_PNOISE = 32'(((64'd2 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [31:0] DEF_MNOISE = 32'(64'd7 << FRAC_BITS);

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef enum logic [2:0] {
    NM_DEFAULT, NM_RANDOM, NM_SMALL, NM_ZERO, NM_PN_MAX, NM_MN_MAX
  } noise_mode_e;

  typedef struct packed {
    logic [31:0] est;
    logic [16:0] gain;
  } filter_out_t;

  typedef struct packed {
    row_kind_e   kind;
    reg_idx_e    idx;
    logic [31:0] value;
    logic        typed;
    logic [31:0] est;
    logic [16:0] gain;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h0000_0000, 1'b1, 32'd0, 17'd187},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h7FFF_FFFF, 1'b0, 32'd0, 17'd0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h8000_0000, 1'b0, 32'd0, 17'd0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'hFFFF_FFFF, 1'b0, 32'd0, 17'd0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h0000_0001, 1'b0, 32'd0, 17'd0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h5555_5555, 1'b0, 32'd0, 17'd0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'hAAAA_AAAA, 1'b0, 32'd0, 17'd0},
    '{ROW_WRITE,  REG_MEASURE_NOISE, 32'h0000_0000, 1'b0, 32'd0, 17'd0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'd12345,     1'b1, 32'd12345, 17'd65536},
    '{ROW_WRITE,  REG_PROCESS_NOISE, 32'h0000_0000, 1'b0, 32'd0, 17'd0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h7FFF_FFFF, 1'b1, 32'd12345, 17'd0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h8000_0000, 1'b1, 32'd12345, 17'd0},
    '{ROW_WRITE,  REG_PROCESS_NOISE, 32'hFFFF_FFFF, 1'b0, 32'd0, 17'd0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h8000_0000, 1'b1, 32'h8000_0000, 17'd65536},
    '{ROW_WRITE,  REG_MEASURE_NOISE, 32'hFFFF_FFFF, 1'b0, 32'd0, 17'd0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h7FFF_FFFF, 1'b0, 32'd0, 17'd0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h7FFF_FFFF, 1'b0, 32'd0, 17'd0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h8000_0000, 1'b0, 32'd0, 17'd0},
    '{ROW_WRITE,  REG_PROCESS_NOISE, 32'h0000_0001, 1'b0, 32'd0, 17'd0},
    '{ROW_WRITE,  REG_MEASURE_NOISE, 32'h0000_0001, 1'b0, 32'd0, 17'd0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h0000_FFFF, 1'b0, 32'd0, 17'd0},
    '{ROW_WRITE,  REG_PROCESS_NOISE, DEF_PNOISE,    1'b0, 32'd0, 17'd0},
    '{ROW_WRITE,  REG_MEASURE_NOISE, DEF_MNOISE,    1'b0, 32'd0, 17'd0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h0001_0000, 1'b0, 32'd0, 17'd0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'hFFFF_0000, 1'b0, 32'd0, 17'd0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_idx = 1'b0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] estimate;
  logic [16:0]        gain;

  logic               typed_chk = 1'b0;
  logic [31:0]        typed_est = '0;
  logic [16:0]        typed_gain = '0;

  logic [31:0]        kf_pnoise;
  logic [31:0]        kf_mnoise;
  logic [31:0]        kf_cov;
  logic signed [31:0] kf_est;

  filter_out_t awaited_outputs[$];
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int mismatches = 0;
  int results_checked = 0;
  int noise_writes = 0;
  int zero_gain_steps = 0;
  int full_gain_steps = 0;
  int cycle_count = 0;

  scalar_kalman_filter #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .sample_i   (sample),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .estimate_o (estimate),
    .gain_o     (gain)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic filter_out_t kalman_update(input logic signed [31:0] z);
    logic [32:0]        prior;
    logic [32:0]        denom;
    logic [63:0]        num;
    logic [63:0]        g;
    logic [63:0]        cov;
    logic signed [63:0] zs;
    logic signed [63:0] es;
    logic signed [63:0] diff;
    logic signed [63:0] prod;
    logic signed [63:0] upd;
    logic signed [63:0] nxt;
    filter_out_t        r;
    prior = {1'b0, kf_cov} + {1'b0, kf_pnoise};
    if (prior[32]) begin
      prior = {1'b0, 32'hFFFF_FFFF};
    end
    denom = prior + {1'b0, kf_mnoise};
    g = '0;
    if (denom != '0) begin
      num = ({31'd0, prior} << GAIN_BITS) + {32'd0, denom[32:1]};
      g = num / {31'd0, denom};
    end
    if (g > 64'd65536) begin
      g = 64'd65536;
    end
    zs = z;
    es = kf_est;
    diff = zs - es;
    prod = $signed(g) * diff;
    upd = (prod + 64'sd32768) >>> GAIN_BITS;
    nxt = es + upd;
    if (nxt > 64'sd2147483647) begin
      nxt = 64'sd2147483647;
    end else if (nxt < -64'sd2147483648) begin
      nxt = -64'sd2147483648;
    end
    cov = ((64'd65536 - g) * {31'd0, prior} + 64'd32768) >> GAIN_BITS;
    kf_est = nxt[31:0];
    kf_cov = cov[31:0];
    r.est = nxt[31:0];
    r.gain = g[16:0];
    return r;
  endfunction

  // Results are compared before the accepted sample is predicted, and the
  // register write comes last, so a new setting applies from the next word.
  always @(posedge clk or negedge rst_n) begin
    filter_out_t want;
    if (!rst_n) begin
      kf_pnoise = DEF_PNOISE;
      kf_mnoise = DEF_MNOISE;
      kf_cov    = '0;
      kf_est    = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_outputs.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result word: estimate %h gain %h", estimate, gain);
          end
          mismatches++;
        end else begin
          want = awaited_outputs.pop_front();
          if (want.est !== estimate || want.gain !== gain) begin
            if (mismatches < 10) begin
              $display("result %0d: estimate %h (expected %h), gain %h (expected %h)",
                       results_checked, estimate, want.est, gain, want.gain);
            end
            mismatches++;
          end
          results_checked++;
        end
      end
      if (in_valid && in_ready) begin
        want = kalman_update(sample);
        if (typed_chk) begin
          want = '{est: typed_est, gain: typed_gain};
        end
        if (want.gain == '0) begin
          zero_gain_steps++;
        end
        if (want.gain == GAIN_ONE) begin
          full_gain_steps++;
        end
        awaited_outputs.push_back(want);
      end
      if (cfg_we) begin
        noise_writes++;
        case (reg_idx_e'(cfg_idx))
          REG_PROCESS_NOISE: kf_pnoise = cfg_data;
          REG_MEASURE_NOISE: kf_mnoise = cfg_data;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= (rst_n && $urandom_range(99) >= rx_stall_pct);
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send_sample(input logic [31:0] z, input logic has_typed,
                             input logic [31:0] t_est, input logic [16:0] t_gain);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 48)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    sample     <= z;
    typed_chk  <= has_typed;
    typed_est  <= t_est;
    typed_gain <= t_gain;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaited_outputs.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_noise(input reg_idx_e idx, input logic [31:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int          tx_mix [3];
    int          rx_mix [3];
    noise_mode_e mode;
    logic [31:0] pn;
    logic [31:0] mn;
    logic [31:0] z;
    logic [31:0] trend;
    int          roll;
    tx_mix = '{22, 53, 0};
    rx_mix = '{53, 22, 0};
    trend = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    tx_idle_pct = tx_mix[0];
    rx_stall_pct = rx_mix[0];
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_WRITE) begin
        drain();
        write_noise(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].value);
      end else begin
        send_sample(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed,
                    DIRECTED_ROWS[i].est, DIRECTED_ROWS[i].gain);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = tx_mix[ph];
      rx_stall_pct = rx_mix[ph];
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        mode = noise_mode_e'($urandom_range(0, 5));
        case (mode)
          NM_DEFAULT: begin pn = DEF_PNOISE; mn = DEF_MNOISE; end
          NM_RANDOM:  begin pn = $urandom; mn = $urandom; end
          NM_SMALL:   begin pn = $urandom_range(0, 4000); mn = $urandom_range(0, 1 << 20); end
          NM_ZERO:    begin pn = '0; mn = '0; end
          NM_PN_MAX:  begin pn = 32'hFFFF_FFFF; mn = $urandom; end
          default:    begin pn = $urandom; mn = 32'hFFFF_FFFF; end
        endcase
        drain();
        write_noise(REG_PROCESS_NOISE, pn);
        write_noise(REG_MEASURE_NOISE, mn);
        for (int k = 0; k < SEG_SAMPLES; k++) begin
          roll = $urandom_range(0, 99);
          trend = trend + 32'($urandom_range(0, 1 << 16)) - 32'(1 << 15);
          if (roll < 45) begin
            z = $urandom;
          end else if (roll < 80) begin
            z = trend + 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
          end else if (roll < 90) begin
            case ($urandom_range(0, 3))
              0: z = 32'h7FFF_FFFF;
              1: z = 32'h8000_0000;
              2: z = 32'h0000_0000;
              default: z = 32'hFFFF_FFFF;
            endcase
          end else begin
            z = 32'($urandom_range(0, 511)) - 32'd256;
          end
          send_sample(z, 1'b0, '0, '0);
        end
      end
    end

    drain();
    repeat (30) @(posedge clk);
    mismatches += awaited_outputs.size();
    $display("covered %0d result words under %0d noise register writes,",
             results_checked, noise_writes);
    $display("including %0d steps at zero gain and %0d at full gain; %0d mismatches",
             zero_gain_steps, full_gain_steps, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
